// File: sv/text_console_writer_assert.svh
// ----------------------------------------------------------------------------
// Text console writer assertion macros
// Shared concurrent assertion forms used by the console RTL.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// Same-cycle implication, checked outside of reset.
`define TCW_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("console assertion failed");

// Next-cycle implication, checked outside of reset.
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("console assertion failed");

`endif

// File: sv/tcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer package
// Screen geometry, codes, command and result types shared by the console.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // Screen geometry.
    localparam int COLS  = 80;
    localparam int ROWS  = 25;
    localparam int CELLS = ROWS * COLS;

    // Derived widths.
    localparam int ADDR_W   = $clog2(CELLS);
    localparam int CNT_W    = $clog2(CELLS + 1);
    localparam int ROW_W    = $clog2(ROWS + 1);
    localparam int COL_W    = $clog2(COLS + 1);
    localparam int POS_W    = 12;
    localparam int ROW_IN_W = 5;
    localparam int COL_IN_W = 7;
    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int CELL_W   = CHAR_W + ATTR_W;

    // Command queue between the front and back parts.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Character codes and register reset values.
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_ERROR   = 8'h45;
    localparam logic [ATTR_W-1:0] RESET_DEFAULT_ATTR = 8'd15;
    localparam logic [ATTR_W-1:0] RESET_ERROR_ATTR   = 8'd244;

    typedef enum logic {
        REQ_PUT   = 1'b0,
        REQ_CLEAR = 1'b1
    } t_req;

    typedef enum logic {
        CFG_DEFAULT_ATTR = 1'b0,
        CFG_ERROR_ATTR   = 1'b1
    } t_cfg_index;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_SCROLL,
        S_DONE
    } t_back_state;

    // One result item.
    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             err;
        logic             scr;
    } t_result;

    // One classified command for the back part.
    typedef struct packed {
        logic              do_write;
        logic [ADDR_W-1:0] addr;
        logic [CELL_W-1:0] data;
        logic              do_scroll;
        logic              do_clear;
        t_result           res;
    } t_cmd;

    // Cell index of a row and column; small constant multiply.
    function automatic logic [POS_W-1:0] cell_pos(input logic [POS_W-1:0] row,
                                                   input logic [POS_W-1:0] col);
        cell_pos = POS_W'(row * POS_W'(COLS)) + col;
    endfunction

endpackage

// File: sv/tcw_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Console command queue
// Short register queue that decouples request classification from execution.
// ----------------------------------------------------------------------------
module tcw_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tcw_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    output tcw_pkg::t_cmd o_cmd,
    input  logic          i_pop
);

    tcw_pkg::t_cmd                   r_mem [tcw_pkg::QDEPTH];
    logic [tcw_pkg::QPTR_W-1:0]      r_wr_ptr;
    logic [tcw_pkg::QPTR_W-1:0]      r_rd_ptr;
    logic [tcw_pkg::QCNT_W-1:0]      r_count;
    logic [tcw_pkg::QCNT_W-1:0]      n_count;

    // Status flags.
    assign o_full  = (r_count == tcw_pkg::QCNT_W'(tcw_pkg::QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // Occupancy follows pushes and pops.
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// File: sv/tcw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Console request front end
// Accepts requests, tracks the cursor and registers, and issues commands.
// ----------------------------------------------------------------------------
module tcw_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_req_type,
    input  logic [tcw_pkg::CHAR_W-1:0]     i_char_code,
    input  logic [tcw_pkg::ATTR_W-1:0]     i_attr,
    input  logic                           i_use_cursor,
    input  logic [tcw_pkg::ROW_IN_W-1:0]   i_row,
    input  logic [tcw_pkg::COL_IN_W-1:0]   i_col,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic                           i_cfg_index,
    input  logic [tcw_pkg::ATTR_W-1:0]     i_cfg_data,
    input  logic                           i_q_full,
    input  logic                           i_init_busy,
    output logic                           o_push,
    output tcw_pkg::t_cmd                  o_cmd
);

    logic [tcw_pkg::ROW_W-1:0]  r_cur_row;
    logic [tcw_pkg::COL_W-1:0]  r_cur_col;
    logic [tcw_pkg::ATTR_W-1:0] r_default_attr;
    logic [tcw_pkg::ATTR_W-1:0] r_error_attr;
    logic [tcw_pkg::ROW_W-1:0]  n_cur_row;
    logic [tcw_pkg::COL_W-1:0]  n_cur_col;

    logic                       accept;
    logic                       off_screen;
    logic [tcw_pkg::ATTR_W-1:0] attr_eff;
    logic [tcw_pkg::ROW_W-1:0]  base_row;
    logic [tcw_pkg::COL_W-1:0]  base_col;
    logic [tcw_pkg::ROW_W-1:0]  new_row;
    logic [tcw_pkg::COL_W-1:0]  new_col;
    logic                       scroll;

    assign o_ready     = !i_q_full && !i_init_busy;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && o_ready;
    assign o_push      = accept;

    // Position arithmetic for a put request.
    always_comb begin
        attr_eff   = (i_attr == '0) ? r_default_attr : i_attr;
        off_screen = !i_use_cursor && ((int'(i_row) >= tcw_pkg::ROWS)
                                       || (int'(i_col) >= tcw_pkg::COLS));
        base_row   = i_use_cursor ? r_cur_row : tcw_pkg::ROW_W'(i_row);
        base_col   = i_use_cursor ? r_cur_col : tcw_pkg::COL_W'(i_col);
        new_row    = base_row;
        new_col    = base_col;
        if (i_char_code == tcw_pkg::CH_NEWLINE) begin
            new_row = base_row + 1'b1;
            new_col = '0;
        end else begin
            new_col = base_col + 1'b1;
            if (new_col == tcw_pkg::COL_W'(tcw_pkg::COLS)) begin
                new_col = '0;
                new_row = base_row + 1'b1;
            end
        end
        scroll = (new_row == tcw_pkg::ROW_W'(tcw_pkg::ROWS));
        if (scroll) begin
            new_row = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
        end
    end

    // Classify the request into a command and the next cursor.
    always_comb begin
        o_cmd     = '0;
        n_cur_row = r_cur_row;
        n_cur_col = r_cur_col;
        unique case (tcw_pkg::t_req'(i_req_type))
            tcw_pkg::REQ_CLEAR: begin
                o_cmd.do_clear = 1'b1;
                o_cmd.data     = {r_default_attr, tcw_pkg::CH_SPACE};
                n_cur_row      = '0;
                n_cur_col      = '0;
            end
            tcw_pkg::REQ_PUT: begin
                if (off_screen) begin
                    o_cmd.do_write = 1'b1;
                    o_cmd.addr     = tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1);
                    o_cmd.data     = {r_error_attr, tcw_pkg::CH_ERROR};
                    o_cmd.res.pos  = tcw_pkg::cell_pos(tcw_pkg::POS_W'(i_row),
                                                       tcw_pkg::POS_W'(i_col));
                    o_cmd.res.err  = 1'b1;
                end else begin
                    o_cmd.do_write  = (i_char_code != tcw_pkg::CH_NEWLINE);
                    o_cmd.addr      = tcw_pkg::ADDR_W'(tcw_pkg::cell_pos(
                                          tcw_pkg::POS_W'(base_row),
                                          tcw_pkg::POS_W'(base_col)));
                    o_cmd.data      = {attr_eff, i_char_code};
                    o_cmd.do_scroll = scroll;
                    o_cmd.res.pos   = tcw_pkg::cell_pos(tcw_pkg::POS_W'(new_row),
                                                        tcw_pkg::POS_W'(new_col));
                    o_cmd.res.scr   = scroll;
                    n_cur_row       = new_row;
                    n_cur_col       = new_col;
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // Cursor update on each accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_row <= '0;
            r_cur_col <= '0;
        end else if (accept) begin
            r_cur_row <= n_cur_row;
            r_cur_col <= n_cur_col;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_attr <= tcw_pkg::RESET_DEFAULT_ATTR;
            r_error_attr   <= tcw_pkg::RESET_ERROR_ATTR;
        end else if (i_cfg_valid) begin
            unique case (tcw_pkg::t_cfg_index'(i_cfg_index))
                tcw_pkg::CFG_DEFAULT_ATTR: r_default_attr <= i_cfg_data;
                tcw_pkg::CFG_ERROR_ATTR:   r_error_attr   <= i_cfg_data;
                default: begin
                    r_default_attr <= r_default_attr;
                end
            endcase
        end
    end

endmodule

// File: sv/tcw_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Console execution back end
// Owns the screen store; performs cell writes, scroll and clear sweeps.
// ----------------------------------------------------------------------------
`include "text_console_writer_assert.svh"

module tcw_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  tcw_pkg::t_cmd    i_q_cmd,
    output logic             o_pop,
    output logic             o_init_busy,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output tcw_pkg::t_result o_out_res
);

    // Screen store: character in the low byte, attribute in the high byte.
    logic [tcw_pkg::CELL_W-1:0] r_mem [tcw_pkg::CELLS];
    logic [tcw_pkg::CELL_W-1:0] r_rd_data;

    tcw_pkg::t_back_state       r_state;
    tcw_pkg::t_back_state       n_state;
    logic [tcw_pkg::CNT_W-1:0]  r_cnt;
    logic [tcw_pkg::CNT_W-1:0]  n_cnt;
    logic [tcw_pkg::CELL_W-1:0] r_fill;
    logic [tcw_pkg::CELL_W-1:0] n_fill;
    tcw_pkg::t_result           r_res;
    tcw_pkg::t_result           n_res;
    logic                       r_pipe_valid;
    logic                       n_pipe_valid;
    logic [tcw_pkg::ADDR_W-1:0] r_pipe_addr;
    logic [tcw_pkg::ADDR_W-1:0] n_pipe_addr;
    logic                       r_pipe_blank;
    logic                       n_pipe_blank;
    logic                       r_out_valid;
    tcw_pkg::t_result           r_out_res;

    logic                       slot_free;
    logic                       load_out;
    tcw_pkg::t_result           out_src;
    logic                       wr_en;
    logic [tcw_pkg::ADDR_W-1:0] wr_addr;
    logic [tcw_pkg::CELL_W-1:0] wr_data;
    logic [tcw_pkg::ADDR_W-1:0] rd_addr;

    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_init_busy = (r_state == tcw_pkg::S_INIT);
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out_res;

    // Sequencer: next state, store port control and result loading.
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_fill       = r_fill;
        n_res        = r_res;
        n_pipe_valid = 1'b0;
        n_pipe_addr  = r_pipe_addr;
        n_pipe_blank = r_pipe_blank;
        o_pop        = 1'b0;
        load_out     = 1'b0;
        out_src      = r_res;
        rd_addr      = '0;
        wr_en        = 1'b0;
        wr_addr      = r_pipe_addr;
        wr_data      = r_pipe_blank ? {r_rd_data[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W],
                                       tcw_pkg::CH_SPACE}
                                    : r_rd_data;

        // Second half of a scroll move: write the cell read in the previous cycle.
        if (r_pipe_valid) begin
            wr_en = 1'b1;
        end

        unique case (r_state)
            tcw_pkg::S_INIT: begin
                wr_en   = 1'b1;
                wr_addr = tcw_pkg::ADDR_W'(r_cnt);
                wr_data = {tcw_pkg::RESET_DEFAULT_ATTR, tcw_pkg::CH_SPACE};
                if (r_cnt == tcw_pkg::CNT_W'(tcw_pkg::CELLS - 1)) begin
                    n_cnt   = '0;
                    n_state = tcw_pkg::S_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            tcw_pkg::S_IDLE: begin
                if (i_q_valid) begin
                    if (i_q_cmd.do_clear) begin
                        o_pop   = 1'b1;
                        n_fill  = i_q_cmd.data;
                        n_res   = i_q_cmd.res;
                        n_cnt   = '0;
                        n_state = tcw_pkg::S_CLEAR;
                    end else if (i_q_cmd.do_scroll) begin
                        o_pop   = 1'b1;
                        wr_en   = i_q_cmd.do_write;
                        wr_addr = i_q_cmd.addr;
                        wr_data = i_q_cmd.data;
                        n_res   = i_q_cmd.res;
                        n_cnt   = '0;
                        n_state = tcw_pkg::S_SCROLL;
                    end else if (slot_free) begin
                        o_pop    = 1'b1;
                        wr_en    = i_q_cmd.do_write;
                        wr_addr  = i_q_cmd.addr;
                        wr_data  = i_q_cmd.data;
                        load_out = 1'b1;
                        out_src  = i_q_cmd.res;
                    end
                end
            end
            tcw_pkg::S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = tcw_pkg::ADDR_W'(r_cnt);
                wr_data = r_fill;
                if (r_cnt == tcw_pkg::CNT_W'(tcw_pkg::CELLS - 1)) begin
                    n_cnt   = '0;
                    n_state = tcw_pkg::S_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            tcw_pkg::S_SCROLL: begin
                // Rows move up by one; the bottom row is reread and blanked.
                if (r_cnt != tcw_pkg::CNT_W'(tcw_pkg::CELLS)) begin
                    if (r_cnt < tcw_pkg::CNT_W'(tcw_pkg::CELLS - tcw_pkg::COLS)) begin
                        rd_addr      = tcw_pkg::ADDR_W'(r_cnt + tcw_pkg::CNT_W'(tcw_pkg::COLS));
                        n_pipe_blank = 1'b0;
                    end else begin
                        rd_addr      = tcw_pkg::ADDR_W'(r_cnt);
                        n_pipe_blank = 1'b1;
                    end
                    n_pipe_valid = 1'b1;
                    n_pipe_addr  = tcw_pkg::ADDR_W'(r_cnt);
                    n_cnt        = r_cnt + 1'b1;
                end else begin
                    n_cnt   = '0;
                    n_state = tcw_pkg::S_DONE;
                end
            end
            tcw_pkg::S_DONE: begin
                if (slot_free) begin
                    load_out = 1'b1;
                    out_src  = r_res;
                    n_state  = tcw_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tcw_pkg::S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= tcw_pkg::S_INIT;
            r_cnt        <= '0;
            r_pipe_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_pipe_valid <= n_pipe_valid;
        end
    end

    // Payload registers of the sequencer.
    always_ff @(posedge i_clk) begin
        r_fill       <= n_fill;
        r_res        <= n_res;
        r_pipe_addr  <= n_pipe_addr;
        r_pipe_blank <= n_pipe_blank;
    end

    // Output register; a finished result waits here for the receiver.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_res <= out_src;
        end
    end

    // Screen store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // No command leaves the queue while the store is being initialized.
    `TCW_ASSERT_IMPL(a_no_pop_in_init, i_clk, i_rst_n, r_state == tcw_pkg::S_INIT, !o_pop)
    // A result is only loaded when the output register is free or draining.
    `TCW_ASSERT_IMPL(a_load_when_free, i_clk, i_rst_n, load_out && r_out_valid, i_out_ready)
    // The scroll sweep ends with its last move written and the result pending.
    `TCW_ASSERT_NEXT(a_scroll_ends, i_clk, i_rst_n, (r_state == tcw_pkg::S_SCROLL) && (r_cnt == tcw_pkg::CNT_W'(tcw_pkg::CELLS)), (r_state == tcw_pkg::S_DONE) && !r_pipe_valid)
    // Sweep counter never passes the store size.
    `TCW_ASSERT_IMPL(a_cnt_bound, i_clk, i_rst_n, r_state != tcw_pkg::S_IDLE, r_cnt <= tcw_pkg::CNT_W'(tcw_pkg::CELLS))

endmodule

// File: sv/text_console_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer
// 80x25 character/attribute screen store with cursor, put and clear requests.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis stream: tuser carries the request type (put or
// clear) and tdata the character, attribute, cursor select, row and column.
// Each request returns one result on the m_axis stream: the new cursor cell
// (or the raw position on an off-screen write) in tdata, error and scrolled
// flags in tuser. Attributes are set through the cfg write channel, which is
// always ready.
// A plain put or newline is held in the command queue and then in the output
// register; the block sustains one per cycle through its two-entry command
// queue while the receiver is ready and no scroll or clear is running. A scroll
// walks the store through its single read and write port; a clear writes
// every cell. After reset the store is filled with blanks of attribute 15,
// one cell per cycle; s_axis_tready stays low during that pass.
// A stalled receiver holds the result in the output register; the queue keeps
// taking requests until it is full, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module text_console_writer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // char_code[7:0], attr[15:8], use_cursor[16],
                                       // row[21:17], col[28:22], zero[31:29]
    input  logic        s_axis_tuser,  // req_type[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // position[11:0], zero[15:12]
    output logic [1:0]  m_axis_tuser,  // error[0], scrolled[1]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    logic             q_full;
    logic             q_valid;
    logic             push;
    logic             pop;
    logic             init_busy;
    tcw_pkg::t_cmd    front_cmd;
    tcw_pkg::t_cmd    q_cmd;
    tcw_pkg::t_result out_res;

    // Front: accept and classify requests.
    tcw_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_req_type   (s_axis_tuser),
        .i_char_code  (s_axis_tdata[7:0]),
        .i_attr       (s_axis_tdata[15:8]),
        .i_use_cursor (s_axis_tdata[16]),
        .i_row        (s_axis_tdata[21:17]),
        .i_col        (s_axis_tdata[28:22]),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_q_full     (q_full),
        .i_init_busy  (init_busy),
        .o_push       (push),
        .o_cmd        (front_cmd)
    );

    // Command queue between the two parts.
    tcw_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (pop)
    );

    // Back: execute commands on the screen store.
    tcw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_pop       (pop),
        .o_init_busy (init_busy),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_res   (out_res)
    );

    // Result packing.
    assign m_axis_tdata = {4'b0000, out_res.pos};
    assign m_axis_tuser = {out_res.scr, out_res.err};

endmodule
